>>> sv/voxel_line_of_sight_ray_macros.svh
// Assertion macros for the voxel line-of-sight block.
`ifndef VOXEL_LINE_OF_SIGHT_RAY_MACROS_SVH
`define VOXEL_LINE_OF_SIGHT_RAY_MACROS_SVH

`ifndef SYNTHESIS
`define VLOS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("voxel_line_of_sight_ray: assertion failed");
`define VLOS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("voxel_line_of_sight_ray: assertion failed");
`else
`define VLOS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VLOS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> sv/vlos_pkg.sv
package vlos_pkg;

    localparam int XF_W      = 6;
    localparam int YF_W      = 6;
    localparam int ZF_W      = 4;
    localparam int ERR_W     = 8;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_CLR_MORE,
        C_NO_IN,
        C_WRITE,
        C_ZERO,
        C_HIT,
        C_LAST,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [2:0] {
        U_CLEAR,
        U_IDLE,
        U_DISP,
        U_WMOD,
        U_STEP,
        U_FHIT,
        U_FEND
    } upc_t;

    typedef enum logic {
        RD_IN,
        RD_NEXT
    } rsel_t;

    typedef enum logic {
        O_HIT,
        O_END
    } osel_t;

    // next step: c1 ? t1 : c2 ? t2 : t3
    typedef struct packed {
        cond_t c1;
        upc_t  t1;
        cond_t c2;
        upc_t  t2;
        upc_t  t3;
        logic  in_rdy;
        logic  clr_wr;
        logic  setup;
        logic  wr_cell;
        logic  adv;
        logic  out_ld;
        rsel_t rsel;
        osel_t osel;
    } uword_t;

    typedef struct packed {
        logic clr_more;
        logic in_acc;
        logic is_cast;
        logic zero_steps;
        logic hit;
        logic last_step;
        logic out_busy;
    } flags_t;

    function automatic uword_t urom(input upc_t pc);
        uword_t w;
        w      = '0;
        w.c1   = C_NEVER;
        w.c2   = C_NEVER;
        w.t1   = U_IDLE;
        w.t2   = U_IDLE;
        w.t3   = U_IDLE;
        w.rsel = RD_IN;
        w.osel = O_HIT;
        unique case (pc)
            U_CLEAR: begin
                w.clr_wr = 1'b1;
                w.c1     = C_CLR_MORE;
                w.t1     = U_CLEAR;
                w.t3     = U_IDLE;
            end
            U_IDLE: begin
                w.in_rdy = 1'b1;
                w.c1     = C_NO_IN;
                w.t1     = U_IDLE;
                w.t3     = U_DISP;
            end
            U_DISP: begin
                w.setup = 1'b1;
                w.rsel  = RD_IN;
                w.c1    = C_WRITE;
                w.t1    = U_WMOD;
                w.c2    = C_ZERO;
                w.t2    = U_FEND;
                w.t3    = U_STEP;
            end
            U_WMOD: begin
                w.wr_cell = 1'b1;
                w.c1      = C_ALWAYS;
                w.t1      = U_IDLE;
            end
            U_STEP: begin
                w.adv  = 1'b1;
                w.rsel = RD_NEXT;
                w.c1   = C_HIT;
                w.t1   = U_FHIT;
                w.c2   = C_LAST;
                w.t2   = U_FEND;
                w.t3   = U_STEP;
            end
            U_FHIT: begin
                w.out_ld = 1'b1;
                w.osel   = O_HIT;
                w.c1     = C_OUT_BUSY;
                w.t1     = U_FHIT;
                w.t3     = U_IDLE;
            end
            U_FEND: begin
                w.out_ld = 1'b1;
                w.osel   = O_END;
                w.c1     = C_OUT_BUSY;
                w.t1     = U_FEND;
                w.t3     = U_IDLE;
            end
            default: begin
                w.c1 = C_ALWAYS;
                w.t1 = U_CLEAR;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/vlos_ram.sv
module vlos_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/vlos_useq.sv
module vlos_useq (
    input  logic             aclk,
    input  logic             aresetn,
    input  vlos_pkg::flags_t flags,
    output vlos_pkg::uword_t uw
);

    import vlos_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t uw_cur;

    function automatic logic cond_true(input cond_t c, input flags_t f);
        logic r;
        unique case (c)
            C_NEVER:    r = 1'b0;
            C_ALWAYS:   r = 1'b1;
            C_CLR_MORE: r = f.clr_more;
            C_NO_IN:    r = !f.in_acc;
            C_WRITE:    r = !f.is_cast;
            C_ZERO:     r = f.zero_steps;
            C_HIT:      r = f.hit;
            C_LAST:     r = f.last_step;
            C_OUT_BUSY: r = f.out_busy;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    assign uw_cur = urom(upc_reg);
    assign uw     = uw_cur;

    always_comb begin
        priority if (cond_true(uw_cur.c1, flags)) begin
            upc_next = uw_cur.t1;
        end else if (cond_true(uw_cur.c2, flags)) begin
            upc_next = uw_cur.t2;
        end else begin
            upc_next = uw_cur.t3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_CLEAR;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> sv/vlos_dpath.sv
module vlos_dpath #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64,
    parameter int MAP_DEPTH  = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  vlos_pkg::uword_t           uw,
    output vlos_pkg::flags_t           flags,
    input  logic                       s_tvalid,
    input  logic                       in_func,
    input  logic [vlos_pkg::XF_W-1:0]  in_pos_x,
    input  logic [vlos_pkg::YF_W-1:0]  in_pos_y,
    input  logic [vlos_pkg::ZF_W-1:0]  in_pos_z,
    input  logic [vlos_pkg::XF_W-1:0]  in_end_x,
    input  logic [vlos_pkg::YF_W-1:0]  in_end_y,
    input  logic [vlos_pkg::ZF_W-1:0]  in_end_z,
    input  logic                       in_solid,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [vlos_pkg::XF_W-1:0]  hit_x,
    output logic [vlos_pkg::YF_W-1:0]  hit_y,
    output logic [vlos_pkg::ZF_W-1:0]  hit_z,
    output logic                       blocked
);

    import vlos_pkg::*;

    localparam int FX    = 1 << XF_W;
    localparam int FY    = 1 << YF_W;
    localparam int FZ    = 1 << ZF_W;
    localparam int EFF_W = (MAP_WIDTH  < FX) ? MAP_WIDTH  : FX;
    localparam int EFF_H = (MAP_HEIGHT < FY) ? MAP_HEIGHT : FY;
    localparam int EFF_D = (MAP_DEPTH  < FZ) ? MAP_DEPTH  : FZ;
    localparam int XB    = $clog2(EFF_W);
    localparam int YB    = $clog2(EFF_H);
    localparam int ZB    = $clog2(EFF_D);
    localparam int ROW_W = 1 << XB;
    localparam int RA_W  = YB + ZB;
    localparam int ROWS  = 1 << RA_W;
    localparam int D_W   = XF_W;
    localparam int E2_W  = ERR_W + 2;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    function automatic logic in_map(input logic [XF_W-1:0] x, input logic [YF_W-1:0] y,
                                    input logic [ZF_W-1:0] z);
        return (32'(x) < MAP_WIDTH) && (32'(y) < MAP_HEIGHT) && (32'(z) < MAP_DEPTH);
    endfunction

    function automatic logic [RA_W-1:0] row_addr(input logic [YF_W-1:0] y,
                                                 input logic [ZF_W-1:0] z);
        return {z[ZB-1:0], y[YB-1:0]};
    endfunction

    // transaction registers
    logic            func_reg;
    logic [XF_W-1:0] px_reg, ex_reg;
    logic [YF_W-1:0] py_reg, ey_reg;
    logic [ZF_W-1:0] pz_reg, ez_reg;
    logic            solid_reg;

    // walk registers
    logic [XF_W-1:0]         cx_reg, nx;
    logic [YF_W-1:0]         cy_reg, ny;
    logic [ZF_W-1:0]         cz_reg, nz;
    logic                    negx_reg, negy_reg, negz_reg;
    axis_t                   major_reg;
    logic [D_W-1:0]          dmaj_reg, dmin1_reg, dmin2_reg;
    logic signed [ERR_W-1:0] ef_reg, es_reg;
    logic [D_W-1:0]          steps_reg;

    logic [RA_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic            m_tvalid_reg, m_tvalid_next;
    logic [XF_W-1:0] hx_reg;
    logic [YF_W-1:0] hy_reg;
    logic [ZF_W-1:0] hz_reg;
    logic            blk_reg;

    // setup
    logic           s_negx, s_negy, s_negz;
    logic [D_W-1:0] adx, ady, adz;
    axis_t          s_major;
    logic [D_W-1:0] s_dmaj, s_d1, s_d2;
    logic [E2_W-1:0] s_ef, s_es;

    // step
    logic            ef_pos, es_pos;
    logic            mv_x, mv_y, mv_z;
    logic [E2_W-1:0] ef_nx, es_nx, sub2;
    logic            hit;
    logic            adv_en;
    logic            in_acc;
    logic            out_busy;
    logic            out_ld;

    // memory
    logic             ram_we;
    logic [RA_W-1:0]  ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata, mod_row;

    always_comb begin
        s_negx = px_reg > ex_reg;
        s_negy = py_reg > ey_reg;
        s_negz = pz_reg > ez_reg;
        adx    = s_negx ? (px_reg - ex_reg) : (ex_reg - px_reg);
        ady    = s_negy ? (py_reg - ey_reg) : (ey_reg - py_reg);
        adz    = D_W'(s_negz ? (pz_reg - ez_reg) : (ez_reg - pz_reg));
        priority if (adx >= ady && adx >= adz) begin
            s_major = AX_X;
        end else if (ady >= adz) begin
            s_major = AX_Y;
        end else begin
            s_major = AX_Z;
        end
        unique case (s_major)
            AX_X: begin
                s_dmaj = adx;
                s_d1   = ady;
                s_d2   = adz;
            end
            AX_Y: begin
                s_dmaj = ady;
                s_d1   = adx;
                s_d2   = adz;
            end
            AX_Z: begin
                s_dmaj = adz;
                s_d1   = ady;
                s_d2   = adx;
            end
            default: begin
                s_dmaj = adx;
                s_d1   = ady;
                s_d2   = adz;
            end
        endcase
        s_ef = {3'b000, s_d1, 1'b0} - {4'b0000, s_dmaj};
        s_es = {3'b000, s_d2, 1'b0} - {4'b0000, s_dmaj};
    end

    always_comb begin
        ef_pos = !ef_reg[ERR_W-1] && (ef_reg != '0);
        es_pos = !es_reg[ERR_W-1] && (es_reg != '0);
        sub2   = {3'b000, dmaj_reg, 1'b0};
        ef_nx  = {{2{ef_reg[ERR_W-1]}}, ef_reg} - (ef_pos ? sub2 : '0)
                 + {3'b000, dmin1_reg, 1'b0};
        es_nx  = {{2{es_reg[ERR_W-1]}}, es_reg} - (es_pos ? sub2 : '0)
                 + {3'b000, dmin2_reg, 1'b0};
        mv_x   = (major_reg == AX_X) || (major_reg == AX_Y && ef_pos)
                 || (major_reg == AX_Z && es_pos);
        mv_y   = (major_reg == AX_Y) || (major_reg != AX_Y && ef_pos);
        mv_z   = (major_reg == AX_Z) || (major_reg != AX_Z && es_pos);
        nx     = mv_x ? (negx_reg ? cx_reg - 1'b1 : cx_reg + 1'b1) : cx_reg;
        ny     = mv_y ? (negy_reg ? cy_reg - 1'b1 : cy_reg + 1'b1) : cy_reg;
        nz     = mv_z ? (negz_reg ? cz_reg - 1'b1 : cz_reg + 1'b1) : cz_reg;
    end

    assign hit    = ram_rdata[cx_reg[XB-1:0]] && in_map(cx_reg, cy_reg, cz_reg);
    assign adv_en = uw.adv && !hit;
    assign in_acc = s_tvalid && uw.in_rdy;

    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_ld   = uw.out_ld && !out_busy;

    always_comb begin
        mod_row                 = ram_rdata;
        mod_row[px_reg[XB-1:0]] = solid_reg;
    end

    assign ram_we    = uw.clr_wr || (uw.wr_cell && in_map(px_reg, py_reg, pz_reg));
    assign ram_waddr = uw.clr_wr ? clr_cnt_reg : row_addr(py_reg, pz_reg);
    assign ram_wdata = uw.clr_wr ? '0 : mod_row;
    assign ram_raddr = (uw.rsel == RD_NEXT) ? row_addr(ny, nz) : row_addr(py_reg, pz_reg);

    vlos_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (ROWS)
    ) u_occ (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign clr_cnt_next = uw.clr_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_comb begin
        if (out_ld) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            func_reg  <= in_func;
            px_reg    <= in_pos_x;
            py_reg    <= in_pos_y;
            pz_reg    <= in_pos_z;
            ex_reg    <= in_end_x;
            ey_reg    <= in_end_y;
            ez_reg    <= in_end_z;
            solid_reg <= in_solid;
        end
        if (uw.setup) begin
            cx_reg    <= px_reg;
            cy_reg    <= py_reg;
            cz_reg    <= pz_reg;
            negx_reg  <= s_negx;
            negy_reg  <= s_negy;
            negz_reg  <= s_negz;
            major_reg <= s_major;
            dmaj_reg  <= s_dmaj;
            dmin1_reg <= s_d1;
            dmin2_reg <= s_d2;
            ef_reg    <= s_ef[ERR_W-1:0];
            es_reg    <= s_es[ERR_W-1:0];
            steps_reg <= s_dmaj;
        end else if (adv_en) begin
            cx_reg    <= nx;
            cy_reg    <= ny;
            cz_reg    <= nz;
            ef_reg    <= ef_nx[ERR_W-1:0];
            es_reg    <= es_nx[ERR_W-1:0];
            steps_reg <= steps_reg - 1'b1;
        end
        if (out_ld) begin
            unique case (uw.osel)
                O_HIT: begin
                    hx_reg  <= cx_reg;
                    hy_reg  <= cy_reg;
                    hz_reg  <= cz_reg;
                    blk_reg <= 1'b1;
                end
                O_END: begin
                    hx_reg  <= ex_reg;
                    hy_reg  <= ey_reg;
                    hz_reg  <= ez_reg;
                    blk_reg <= 1'b0;
                end
                default: begin
                    hx_reg  <= ex_reg;
                    hy_reg  <= ey_reg;
                    hz_reg  <= ez_reg;
                    blk_reg <= 1'b0;
                end
            endcase
        end
    end

    assign flags.clr_more   = clr_cnt_reg != '1;
    assign flags.in_acc     = in_acc;
    assign flags.is_cast    = func_reg;
    assign flags.zero_steps = s_dmaj == '0;
    assign flags.hit        = hit;
    assign flags.last_step  = steps_reg == D_W'(1);
    assign flags.out_busy   = out_busy;

    assign m_tvalid = m_tvalid_reg;
    assign hit_x    = hx_reg;
    assign hit_y    = hy_reg;
    assign hit_z    = hz_reg;
    assign blocked  = blk_reg;

endmodule

>>> sv/voxel_line_of_sight_ray.sv
// channel | dir | tdata (lsb first)                                   | tuser
// s_      | in  | pos_x, pos_y, pos_z, end_x, end_y, end_z, solid, pad | func
// m_      | out | hit_x, hit_y, hit_z                                  | blocked
//
// Cast: the voxels tested number at most the major-axis span (63);
//   one occupancy RAM row read per tested voxel sets the pace.
// After reset a clearing pass writes every RAM row, one per cycle (1024 rows
//   at the default map size); s_tready stays low until it ends.
// A result waiting on m_tready stalls only the final step of the next cast.
`include "voxel_line_of_sight_ray_macros.svh"

module voxel_line_of_sight_ray #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64,
    parameter int MAP_DEPTH  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, pos_z, end_x, end_y, end_z, solid, zero fill
    input  logic [vlos_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit_x, hit_y, hit_z
    output logic [vlos_pkg::M_TDATA_W-1:0]   m_tdata,
    // blocked
    output logic [0:0]                       m_tuser
);

    import vlos_pkg::*;

    uword_t          uw;
    flags_t          flags;
    logic [XF_W-1:0] hit_x;
    logic [YF_W-1:0] hit_y;
    logic [ZF_W-1:0] hit_z;
    logic            blocked;

    vlos_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uw      (uw)
    );

    vlos_dpath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .MAP_DEPTH  (MAP_DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .uw       (uw),
        .flags    (flags),
        .s_tvalid (s_tvalid),
        .in_func  (s_tuser[0]),
        .in_pos_x (s_tdata[5:0]),
        .in_pos_y (s_tdata[11:6]),
        .in_pos_z (s_tdata[15:12]),
        .in_end_x (s_tdata[21:16]),
        .in_end_y (s_tdata[27:22]),
        .in_end_z (s_tdata[31:28]),
        .in_solid (s_tdata[32]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .hit_x    (hit_x),
        .hit_y    (hit_y),
        .hit_z    (hit_z),
        .blocked  (blocked)
    );

    assign s_tready = uw.in_rdy;
    assign m_tdata  = {hit_z, hit_y, hit_x};
    assign m_tuser  = blocked;

    `VLOS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `VLOS_ASSERT_NXT(a_write_no_result, aclk, aresetn, s_tvalid && s_tready && !s_tuser[0], !$rose(m_tvalid))
    `VLOS_ASSERT_NXT(a_no_result_from_idle, aclk, aresetn, s_tready, !$rose(m_tvalid))

endmodule

>>> tb/sv/tb_voxel_line_of_sight_ray.sv
`timescale 1ns / 100ps

module tb_voxel_line_of_sight_ray;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    localparam int N_RANDOM       = 1600;
    localparam int QUIET_TAIL     = 250;
    localparam int SCENE_LEN      = 40;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 6000;

    // s_tdata, lsb first: px, py, pz, ex, ey, ez, solid
    typedef struct packed {
        logic       solid;
        logic [3:0] ez;
        logic [5:0] ey;
        logic [5:0] ex;
        logic [3:0] pz;
        logic [5:0] py;
        logic [5:0] px;
    } ray_item_t;

    // {m_tuser, m_tdata}
    typedef struct packed {
        logic       blocked;
        logic [3:0] hz;
        logic [5:0] hy;
        logic [5:0] hx;
    } hit_report_t;

    class ray_hit_tracker;
        bit          occ[65536];
        hit_report_t pending_hits[$];
        int          errors;
        int          writes;
        int          casts;
        int          blocked_casts;

        function void note_transaction(logic fn, ray_item_t it);
            int          p[3];
            int          e[3];
            int          d[3];
            int          dir[3];
            int          mj, m1, m2;
            int          err1, err2, n;
            bit          hit;
            hit_report_t exp;
            if (fn == FUNC_WRITE) begin
                occ[{it.pz, it.py, it.px}] = it.solid;
                writes++;
                return;
            end
            casts++;
            p[0] = int'(it.px); p[1] = int'(it.py); p[2] = int'(it.pz);
            e[0] = int'(it.ex); e[1] = int'(it.ey); e[2] = int'(it.ez);
            for (int k = 0; k < 3; k++) begin
                d[k]   = (p[k] > e[k]) ? p[k] - e[k] : e[k] - p[k];
                dir[k] = (p[k] < e[k]) ? 1 : ((p[k] == e[k]) ? 0 : -1);
            end
            if (d[0] >= d[1] && d[0] >= d[2]) begin
                mj = 0; m1 = 1; m2 = 2;
            end else if (d[1] >= d[2]) begin
                mj = 1; m1 = 0; m2 = 2;
            end else begin
                mj = 2; m1 = 1; m2 = 0;
            end
            err1 = 2 * d[m1] - d[mj];
            err2 = 2 * d[m2] - d[mj];
            n    = d[mj];
            hit  = 1'b0;
            while (n > 0 && !hit) begin
                if (occ[p[2] * 4096 + p[1] * 64 + p[0]]) begin
                    hit = 1'b1;
                end else begin
                    if (err1 > 0) begin
                        p[m1] += dir[m1];
                        err1  -= 2 * d[mj];
                    end
                    if (err2 > 0) begin
                        p[m2] += dir[m2];
                        err2  -= 2 * d[mj];
                    end
                    err1  += 2 * d[m1];
                    err2  += 2 * d[m2];
                    p[mj] += dir[mj];
                    n--;
                end
            end
            exp.blocked = hit;
            if (hit) begin
                blocked_casts++;
                exp.hx = 6'(p[0]);
                exp.hy = 6'(p[1]);
                exp.hz = 4'(p[2]);
            end else begin
                exp.hx = it.ex;
                exp.hy = it.ey;
                exp.hz = it.ez;
            end
            pending_hits.insert(pending_hits.size(), exp);
        endfunction

        function void check_hit(hit_report_t act);
            hit_report_t exp;
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $time, act);
                errors++;
                return;
            end
            exp = pending_hits.pop_front();
            if (act.hx !== exp.hx) begin
                $display("%0t: hit_x expected %0d, actual %0d", $time, exp.hx, act.hx);
                errors++;
            end
            if (act.hy !== exp.hy) begin
                $display("%0t: hit_y expected %0d, actual %0d", $time, exp.hy, act.hy);
                errors++;
            end
            if (act.hz !== exp.hz) begin
                $display("%0t: hit_z expected %0d, actual %0d", $time, exp.hz, act.hz);
                errors++;
            end
            if (act.blocked !== exp.blocked) begin
                $display("%0t: blocked expected %0d, actual %0d", $time, exp.blocked,
                         act.blocked);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_hits.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [vlos_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]                     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [vlos_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0]                     m_tuser;

    ray_hit_tracker tracker = new();
    bit             quiet   = 1'b0;
    int             idle_cycles = 0;

    voxel_line_of_sight_ray dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            tracker.note_transaction(s_tuser[0], s_tdata[$bits(ray_item_t)-1:0]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_hit({m_tuser[0], m_tdata});
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // receiver back-pressure
    initial begin
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    task automatic send_item(input logic fn, input ray_item_t it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tuser  <= fn;
        s_tdata  <= {{(vlos_pkg::S_TDATA_W - $bits(ray_item_t)){1'b0}}, it};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(input logic fn, input int px, input int py, input int pz,
                               input int ex, input int ey, input int ez, input logic sd);
        ray_item_t it;
        it.px = 6'(px); it.py = 6'(py); it.pz = 4'(pz);
        it.ex = 6'(ex); it.ey = 6'(ey); it.ez = 4'(ez);
        it.solid = sd;
        send_item(fn, it);
    endtask

    task automatic run_random();
        ray_item_t it;
        logic      fn;
        int        bx, by, bz;
        int        roll;
        bx = 0; by = 0; bz = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % SCENE_LEN == 0) begin
                bx = $urandom_range(0, 56);
                by = $urandom_range(0, 56);
                bz = $urandom_range(0, 12);
            end
            if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            roll     = $urandom_range(0, 99);
            it.px    = 6'($urandom_range(0, 63));
            it.py    = 6'($urandom_range(0, 63));
            it.pz    = 4'($urandom_range(0, 15));
            it.ex    = 6'($urandom_range(0, 63));
            it.ey    = 6'($urandom_range(0, 63));
            it.ez    = 4'($urandom_range(0, 15));
            it.solid = 1'($urandom_range(0, 1));
            fn       = FUNC_CAST;
            if (roll < 45) begin
                // build obstacles inside the local box
                fn       = FUNC_WRITE;
                it.px    = 6'(bx + $urandom_range(0, 7));
                it.py    = 6'(by + $urandom_range(0, 7));
                it.pz    = 4'(bz + $urandom_range(0, 3));
                it.solid = (roll < 33);
            end else if (roll < 85) begin
                it.px = 6'(bx + $urandom_range(0, 7));
                it.py = 6'(by + $urandom_range(0, 7));
                it.pz = 4'(bz + $urandom_range(0, 3));
                it.ex = 6'(bx + $urandom_range(0, 7));
                it.ey = 6'(by + $urandom_range(0, 7));
                it.ez = 4'(bz + $urandom_range(0, 3));
            end else if (roll < 90) begin
                // long ray leaving the box
                it.px = 6'(bx + $urandom_range(0, 7));
                it.py = 6'(by + $urandom_range(0, 7));
                it.pz = 4'(bz + $urandom_range(0, 3));
            end else if (roll < 96) begin
                fn = FUNC_CAST;
            end else begin
                fn = FUNC_WRITE;
            end
            send_item(fn, it);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_fields(FUNC_CAST,   0,  0,  0, 63, 63, 15, 1'b0);
        send_fields(FUNC_WRITE,  0,  0,  0, 63, 63, 15, 1'b1);
        send_fields(FUNC_CAST,   0,  0,  0,  5,  3,  1, 1'b1);   // solid start
        send_fields(FUNC_CAST,   0,  0,  0,  0,  0,  0, 1'b0);   // start = end, solid
        send_fields(FUNC_CAST,  63, 63, 15,  0,  0,  0, 1'b0);   // end never tested
        send_fields(FUNC_WRITE, 63, 63, 15, 63, 63, 15, 1'b1);
        send_fields(FUNC_CAST,  63, 63, 15, 63, 63, 15, 1'b1);
        send_fields(FUNC_CAST,   1,  1,  0, 63, 63, 15, 1'b0);
        send_fields(FUNC_WRITE,  0,  0,  0,  0,  0,  0, 1'b0);
        send_fields(FUNC_WRITE, 10,  0,  0,  0,  0,  0, 1'b1);
        send_fields(FUNC_CAST,   0,  0,  0, 20,  0,  0, 1'b0);   // x major
        send_fields(FUNC_WRITE,  5, 40,  3,  0,  0,  0, 1'b1);
        send_fields(FUNC_CAST,   5,  0,  3,  5, 63,  3, 1'b0);   // y major
        send_fields(FUNC_WRITE,  2,  2, 12,  0,  0,  0, 1'b1);
        send_fields(FUNC_CAST,   2,  2,  0,  2,  2, 15, 1'b0);   // z major
        send_fields(FUNC_CAST,  30, 30,  0, 30, 45, 15, 1'b0);   // y/z tie
        send_fields(FUNC_CAST,  20, 20,  5, 35, 35,  5, 1'b0);   // x/y tie
        send_fields(FUNC_CAST,  40, 40, 10, 20, 30,  2, 1'b0);
        send_fields(FUNC_CAST,  12,  3,  1,  0,  0,  0, 1'b0);
        send_fields(FUNC_WRITE, 63, 63, 15,  0,  0,  0, 1'b0);
        send_fields(FUNC_CAST,  63, 63, 15,  0,  0,  0, 1'b0);
        send_fields(FUNC_CAST,  63, 63, 15, 63, 63, 15, 1'b0);

        run_random();
        s_tvalid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d cell writes and %0d ray casts, %0d of them stopped by a solid voxel.",
                 tracker.writes, tracker.casts, tracker.blocked_casts);
        if (tracker.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches seen", tracker.errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
